### hw/rtl/fpm_pkg.sv
// Shared types and constants for the flow pulse monitor.
// Used by fpm_div, flow_pulse_monitor and the testbench; depends on nothing else.
package fpm_pkg;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_CAL        = 2'd0;
    localparam logic [1:0] REG_START_TO   = 2'd1;
    localparam logic [1:0] REG_NO_FLOW_TO = 2'd2;

    localparam logic [31:0] WINDOW_MIN_MS = 32'd5000;
    localparam logic [16:0] RATE_SCALE    = 17'd100000;
    localparam logic [16:0] MS_PER_MIN    = 17'd60000;
    localparam logic [9:0]  MS_PER_SEC    = 10'd1000;

    // Product of a 32-bit value and a 17-bit scale, and the divider numerator
    // with one bit of headroom for the rounding offset.
    localparam int PROD_W    = 49;
    localparam int NUM_W     = 50;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        REQ_WAIT    = 2'd0,
        REQ_WINDOW  = 2'd1,
        REQ_OBSERVE = 2'd2,
        REQ_SAMPLE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLAGS,
        S_MUL,
        S_GO,
        S_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        OP_RATE,
        OP_FLOW,
        OP_WATER
    } op_t;

    // One result item; the last field sits in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic        water_valid;
        logic [31:0] water_ml;
        logic [31:0] window_ms;
        logic [31:0] window_pulses;
        logic        flow_saturated;
        logic [31:0] flow_ml_per_min;
        logic [31:0] pulse_rate_x100;
        logic        sample_valid;
        logic        no_flow_timed_out;
        logic        start_timed_out;
        logic        flow_established;
    } out_item_t;

endpackage

### hw/rtl/fpm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on fpm_pkg for the numerator width.
module fpm_div
    import fpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [31:0]      den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    logic [NUM_W-1:0]     nq_reg;
    logic [NUM_W-1:0]     nq_next;
    logic [31:0]          rem_reg;
    logic [31:0]          rem_next;
    logic [31:0]          den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_next;
    logic                 done_reg;
    logic [32:0]          shifted;
    logic [32:0]          diff;
    logic                 ge;

    // The remainder stays below the divisor, so the shifted value fits 33 bits.
    assign shifted = {rem_reg, nq_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            nq_next   = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            nq_next  = {nq_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[31:0] : shifted[31:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = nq_reg;

endmodule

### hw/rtl/flow_pulse_monitor.sv
// Top level of the flow pulse monitor: handshakes, configuration, sequencer.
// Depends on fpm_pkg and on the shared divider fpm_div.

// The monitor takes one request at a time and returns exactly one result
// transfer for it. An accepted request updates the flow-wait and rate-window
// state in the cycle it is taken, the timeout flags are formed in the cycle
// after, and then up to three rounded divisions run one after another on a
// single shared multiplier and a single bit-serial divider: the pulse rate,
// the flow in ml/min (both only for a granted rate sample) and the water
// volume (only when the calibration is nonzero). Each division runs one
// multiply, one divider load, one quotient bit per cycle and a completion
// step. A finished result sits in an output register, so the next request
// is taken while the previous result still waits for its transfer.
// Configuration registers are written with cfg_we and are meant to be
// changed only while no request is in progress.
module flow_pulse_monitor
    import fpm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Request stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // now_ms [31:0], pulse_count [63:32]
    input  logic [1:0]   s_tuser,   // req_type [1:0]
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [167:0] m_tdata,   // flow_established [0], start_timed_out [1],
                                    // no_flow_timed_out [2], sample_valid [3],
                                    // pulse_rate_x100 [35:4], flow_ml_per_min [67:36],
                                    // flow_saturated [68], window_pulses [100:69],
                                    // window_ms [132:101], water_ml [164:133],
                                    // water_valid [165], zero fill [167:166]
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    // Configuration registers.
    logic [31:0] cal_reg;
    logic [15:0] start_to_reg;
    logic [15:0] nf_to_reg;

    // Monitor state.
    logic [31:0] wait_start_reg, wait_start_next;
    logic [31:0] last_pulse_reg, last_pulse_next;
    logic [31:0] last_seen_reg,  last_seen_next;
    logic        flow_seen_reg,  flow_seen_next;
    logic [31:0] win_time_reg,   win_time_next;
    logic [31:0] win_count_reg,  win_count_next;

    // Sequencer and working registers.
    state_t            state_reg, state_next;
    op_t               op_reg,    op_next;
    logic [31:0]       now_reg,   now_next;
    logic [31:0]       cnt_reg,   cnt_next;
    logic [PROD_W-1:0] prod_reg,  prod_next;
    out_item_t         res_reg,   res_next;
    out_item_t         out_reg,   out_next;
    logic              m_valid_reg, m_valid_next;

    // Datapath signals.
    logic [31:0]       in_now;
    logic [31:0]       in_cnt;
    logic [31:0]       win_span;
    logic [31:0]       st_span;
    logic [31:0]       nf_span;
    logic [25:0]       st_limit;
    logic [25:0]       nf_limit;
    logic [31:0]       mul_a;
    logic [16:0]       mul_b;
    logic [PROD_W-1:0] prod_full;
    logic [31:0]       div_den;
    logic [NUM_W-1:0]  div_num;
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;
    logic              div_sat;
    logic [31:0]       div_res;

    assign in_now = s_tdata[31:0];
    assign in_cnt = s_tdata[63:32];

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg      <= '0;
            start_to_reg <= '0;
            nf_to_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_CAL:        cal_reg      <= cfg_wdata;
                REG_START_TO:   start_to_reg <= cfg_wdata[15:0];
                REG_NO_FLOW_TO: nf_to_reg    <= cfg_wdata[15:0];
                default:        ;
            endcase
        end
    end

    // Wrapping time differences and the timeout limits in milliseconds.
    assign win_span = in_now - win_time_reg;
    assign st_span  = now_reg - wait_start_reg;
    assign nf_span  = now_reg - last_pulse_reg;
    assign st_limit = 26'(start_to_reg) * 26'(MS_PER_SEC);
    assign nf_limit = 26'(nf_to_reg) * 26'(MS_PER_SEC);

    // Shared multiplier: scales the divider numerator for each operation.
    always_comb
    begin
        case (op_reg)
            OP_RATE:
            begin
                mul_a   = res_reg.window_pulses;
                mul_b   = RATE_SCALE;
                div_den = res_reg.window_ms;
            end
            OP_FLOW:
            begin
                mul_a   = res_reg.pulse_rate_x100;
                mul_b   = MS_PER_MIN;
                div_den = cal_reg;
            end
            OP_WATER:
            begin
                mul_a   = cnt_reg;
                mul_b   = RATE_SCALE;
                div_den = cal_reg;
            end
            default:
            begin
                mul_a   = cnt_reg;
                mul_b   = RATE_SCALE;
                div_den = cal_reg;
            end
        endcase
    end

    assign prod_full = {17'b0, mul_a} * {32'b0, mul_b};

    // Adding half the divisor before dividing rounds the quotient to nearest.
    assign div_num = {1'b0, prod_reg} + {{(NUM_W - 31){1'b0}}, div_den[31:1]};

    fpm_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // A quotient above 32 bits saturates to all ones.
    assign div_sat = |div_quot[NUM_W-1:32];
    assign div_res = div_sat ? 32'hFFFF_FFFF : div_quot[31:0];

    // Sequencer: next state, state updates and result assembly.
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        now_next        = now_reg;
        cnt_next        = cnt_reg;
        prod_next       = prod_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        wait_start_next = wait_start_reg;
        last_pulse_next = last_pulse_reg;
        last_seen_next  = last_seen_reg;
        flow_seen_next  = flow_seen_reg;
        win_time_next   = win_time_reg;
        win_count_next  = win_count_reg;
        s_tready        = 1'b0;
        div_start       = 1'b0;

        m_valid_next = m_valid_reg && !m_tready;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    now_next   = in_now;
                    cnt_next   = in_cnt;
                    res_next   = '0;
                    state_next = S_FLAGS;
                    case (req_t'(s_tuser))
                        REQ_WAIT:
                        begin
                            wait_start_next = in_now;
                            last_pulse_next = in_now;
                            last_seen_next  = in_cnt;
                            flow_seen_next  = 1'b0;
                        end
                        REQ_WINDOW:
                        begin
                            win_time_next  = in_now;
                            win_count_next = in_cnt;
                        end
                        REQ_OBSERVE:
                        begin
                            if (in_cnt != last_seen_reg)
                            begin
                                last_seen_next  = in_cnt;
                                last_pulse_next = in_now;
                                flow_seen_next  = 1'b1;
                            end
                        end
                        REQ_SAMPLE:
                        begin
                            // A sample needs a long enough window and a calibration.
                            if (win_span >= WINDOW_MIN_MS && cal_reg != '0)
                            begin
                                res_next.sample_valid  = 1'b1;
                                res_next.window_pulses = in_cnt - win_count_reg;
                                res_next.window_ms     = win_span;
                                win_time_next          = in_now;
                                win_count_next         = in_cnt;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_FLAGS:
            begin
                res_next.flow_established  = flow_seen_reg;
                res_next.start_timed_out   = !flow_seen_reg && (st_span >= {6'b0, st_limit});
                res_next.no_flow_timed_out = flow_seen_reg && (nf_span >= {6'b0, nf_limit});
                if (res_reg.sample_valid)
                begin
                    op_next    = OP_RATE;
                    state_next = S_MUL;
                end
                else if (cal_reg != '0)
                begin
                    op_next    = OP_WATER;
                    state_next = S_MUL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_MUL:
            begin
                prod_next  = prod_full;
                state_next = S_GO;
            end

            S_GO:
            begin
                div_start  = 1'b1;
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                if (div_done)
                begin
                    case (op_reg)
                        OP_RATE:
                        begin
                            res_next.pulse_rate_x100 = div_res;
                            op_next    = OP_FLOW;
                            state_next = S_MUL;
                        end
                        OP_FLOW:
                        begin
                            res_next.flow_ml_per_min = div_res;
                            res_next.flow_saturated  = div_sat;
                            op_next    = OP_WATER;
                            state_next = S_MUL;
                        end
                        OP_WATER:
                        begin
                            res_next.water_ml    = div_res;
                            res_next.water_valid = !div_sat;
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_OUT:
            begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_tready)
                begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_RATE;
            m_valid_reg    <= 1'b0;
            wait_start_reg <= '0;
            last_pulse_reg <= '0;
            last_seen_reg  <= '0;
            flow_seen_reg  <= 1'b0;
            win_time_reg   <= '0;
            win_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            m_valid_reg    <= m_valid_next;
            wait_start_reg <= wait_start_next;
            last_pulse_reg <= last_pulse_next;
            last_seen_reg  <= last_seen_next;
            flow_seen_reg  <= flow_seen_next;
            win_time_reg   <= win_time_next;
            win_count_reg  <= win_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;

    // The divider only runs while the sequencer waits for it.
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == S_WAIT)
        else $error("divider busy outside its wait state");

    // A granted sample always has a window of at least the minimum length.
    a_sample_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && out_reg.sample_valid |-> out_reg.window_ms >= WINDOW_MIN_MS)
        else $error("rate sample with a short window");

    // A refused or absent sample carries all-zero sample fields.
    a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !out_reg.sample_valid |->
            out_reg.pulse_rate_x100 == '0 && out_reg.flow_ml_per_min == '0 &&
            !out_reg.flow_saturated && out_reg.window_pulses == '0 &&
            out_reg.window_ms == '0)
        else $error("sample fields set without a sample");

    // The two timeouts belong to opposite flow phases.
    a_timeouts_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_reg.start_timed_out && out_reg.no_flow_timed_out))
        else $error("both timeouts reported");

    // A new request is only taken when the previous one has left the sequencer.
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == S_FLAGS)
        else $error("accepted request did not start processing");

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for flow_pulse_monitor: a directed table, then random meter traffic
// under changing register settings, each result compared against a hand-typed golden
// or an in-bench meter model. Depends on fpm_pkg and the flow_pulse_monitor RTL.
module testbench
    import fpm_pkg::*;
();

    // A request finishes well within the watchdog limit, result stalls included, so that many
    // cycles without any transfer can only mean the block has hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES   = 200;
    localparam int MAX_PRINTED     = 100;

    // One row of the directed table: either a register setting or a request. A request row
    // may carry a golden result typed in by hand; otherwise the model supplies it.
    typedef struct packed {
        logic        is_setting;
        req_t        req;
        logic [31:0] now_ms;
        logic [31:0] count;
        logic [31:0] cal;
        logic [15:0] start_to;
        logic [15:0] no_flow_to;
        logic        typed;
        out_item_t   golden;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic [1:0]   s_tuser = REQ_WAIT;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [167:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = REG_CAL;
    logic [31:0]  cfg_wdata = '0;

    // Meter model: its own copy of the registers and of the flow-wait and rate-window state.
    logic [31:0] cal_x100 = '0;
    logic [15:0] start_to_sec = '0;
    logic [15:0] no_flow_to_sec = '0;
    logic [31:0] wait_start_ms = '0;
    logic [31:0] last_pulse_ms = '0;
    logic [31:0] last_count = '0;
    logic        seen_flow = 1'b0;
    logic [31:0] window_start_ms = '0;
    logic [31:0] window_start_count = '0;

    out_item_t pending_readings[$];
    stim_row_t directed_rows[$];

    logic idle_on = 1'b1;
    int   stall_left = 0;
    int   quiet_cycles = 0;
    int   errors = 0;
    int   items_sent = 0;
    int   results_seen = 0;
    int   settings_used = 0;
    int   samples_granted = 0;
    int   start_timeouts = 0;
    int   no_flow_timeouts = 0;
    int   volumes_saturated = 0;

    flow_pulse_monitor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Rounded division saturated to 32 bits. Bit 32 of the return value is set when the
    // quotient did not fit and the low word was forced to all ones.
    function automatic logic [32:0] round_div_sat(logic [63:0] num, logic [31:0] den);
        logic [63:0] quo;
        quo = (num + {33'd0, den[31:1]}) / {32'd0, den};
        if (quo > 64'hFFFF_FFFF)
            return {1'b1, 32'hFFFF_FFFF};
        return {1'b0, quo[31:0]};
    endfunction

    // Applies one request to the model state and returns the result the block must give.
    // The request acts first; the flags and the volume then see the updated state.
    function automatic out_item_t meter_step(req_t req, logic [31:0] now_ms, logic [31:0] count);
        out_item_t   r;
        logic [31:0] span;
        logic [31:0] elapsed;
        logic [32:0] q;
        r = '0;
        case (req)
            REQ_WAIT:
            begin
                wait_start_ms = now_ms;
                last_pulse_ms = now_ms;
                last_count = count;
                seen_flow = 1'b0;
            end
            REQ_WINDOW:
            begin
                window_start_ms = now_ms;
                window_start_count = count;
            end
            REQ_OBSERVE:
            begin
                if (count != last_count)
                begin
                    last_count = count;
                    last_pulse_ms = now_ms;
                    seen_flow = 1'b1;
                end
            end
            default:
            begin
                // A sample needs a long enough window and a calibration; a refused
                // sample leaves the window running.
                span = now_ms - window_start_ms;
                if (span >= WINDOW_MIN_MS && cal_x100 != '0)
                begin
                    r.sample_valid = 1'b1;
                    r.window_pulses = count - window_start_count;
                    r.window_ms = span;
                    q = round_div_sat({32'd0, r.window_pulses} * 64'(RATE_SCALE), span);
                    r.pulse_rate_x100 = q[31:0];
                    q = round_div_sat({32'd0, r.pulse_rate_x100} * 64'(MS_PER_MIN), cal_x100);
                    r.flow_ml_per_min = q[31:0];
                    r.flow_saturated = q[32];
                    window_start_ms = now_ms;
                    window_start_count = count;
                end
            end
        endcase
        r.flow_established = seen_flow;
        elapsed = now_ms - wait_start_ms;
        r.start_timed_out = !seen_flow && elapsed >= {16'd0, start_to_sec} * 32'(MS_PER_SEC);
        elapsed = now_ms - last_pulse_ms;
        r.no_flow_timed_out = seen_flow && elapsed >= {16'd0, no_flow_to_sec} * 32'(MS_PER_SEC);
        if (cal_x100 != '0)
        begin
            q = round_div_sat({32'd0, count} * 64'(RATE_SCALE), cal_x100);
            r.water_ml = q[31:0];
            r.water_valid = !q[32];
        end
        return r;
    endfunction

    function automatic out_item_t golden_of(logic fe, logic st, logic nf, logic [31:0] water,
                                            logic wv);
        out_item_t g;
        g = '0;
        g.flow_established = fe;
        g.start_timed_out = st;
        g.no_flow_timed_out = nf;
        g.water_ml = water;
        g.water_valid = wv;
        return g;
    endfunction

    task automatic add_row(req_t req, logic [31:0] now_ms, logic [31:0] count, logic typed,
                           out_item_t golden);
        stim_row_t row;
        row = '0;
        row.req = req;
        row.now_ms = now_ms;
        row.count = count;
        row.typed = typed;
        row.golden = golden;
        directed_rows.push_back(row);
    endtask

    task automatic add_setting(logic [31:0] cal, logic [15:0] st, logic [15:0] nf);
        stim_row_t row;
        row = '0;
        row.is_setting = 1'b1;
        row.cal = cal;
        row.start_to = st;
        row.no_flow_to = nf;
        directed_rows.push_back(row);
    endtask

    task automatic report_error(string msg);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                   results_seen, name, got, want));
    endtask

    // Holds off the sender until every outstanding result has been taken. Valid is lowered
    // first and at least one edge passes, so valid never drops and rises in one step.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_readings.size() != 0);
    endtask

    // Every result has arrived once the drain returns, so the block is idle and all three
    // registers can be written back to back.
    task automatic apply_settings(logic [31:0] cal, logic [15:0] st, logic [15:0] nf);
        wait_for_drain();
        cfg_we <= 1'b1;
        cfg_addr <= REG_CAL;
        cfg_wdata <= cal;
        @(posedge clk);
        cfg_addr <= REG_START_TO;
        cfg_wdata <= {16'd0, st};
        @(posedge clk);
        cfg_addr <= REG_NO_FLOW_TO;
        cfg_wdata <= {16'd0, nf};
        @(posedge clk);
        cfg_we <= 1'b0;
        cal_x100 = cal;
        start_to_sec = st;
        no_flow_to_sec = nf;
        settings_used++;
    endtask

    task automatic idle_gap();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Presents one request and holds it until the transfer happens. Ready is read right
    // after the edge, before any register of the block has moved, so it is the value the
    // edge saw. The expected result is queued at the very edge of the transfer.
    task automatic send_request(req_t req, logic [31:0] now_ms, logic [31:0] count,
                                logic typed, out_item_t golden);
        out_item_t predicted;
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {count, now_ms};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = meter_step(req, now_ms, count);
        pending_readings.push_back(typed ? golden : predicted);
        items_sent++;
        if (predicted.sample_valid)
            samples_granted++;
        if (predicted.start_timed_out)
            start_timeouts++;
        if (predicted.no_flow_timed_out)
            no_flow_timeouts++;
        if (predicted.water_ml == 32'hFFFF_FFFF && !predicted.water_valid)
            volumes_saturated++;
    endtask

    function automatic logic [31:0] pick_cal(int phase);
        case (phase % 5)
            0: return '0;
            1: return $urandom_range(50, 100000);
            2: return 32'd1;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short timeouts so that both sides of each threshold are reached often.
    function automatic logic [15:0] pick_timeout();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 15));
        endcase
    endfunction

    // Polling intervals: mostly a few seconds, now and then long enough to pass the
    // larger of the two timeouts, and rarely a jump anywhere on the wrapping clock.
    function automatic logic [31:0] time_step();
        int unsigned pick;
        int unsigned reach;
        pick = $urandom_range(0, 99);
        reach = 1000 * ((start_to_sec > no_flow_to_sec) ? start_to_sec : no_flow_to_sec) + 6000;
        if (pick < 45)
            return $urandom_range(0, 2000);
        if (pick < 80)
            return $urandom_range(2000, 12000);
        if (pick < 96)
            return $urandom_range(0, reach);
        return $urandom;
    endfunction

    function automatic logic [31:0] count_step();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return '0;
        if (pick < 85)
            return $urandom_range(1, 60);
        if (pick < 95)
            return $urandom_range(0, 100000);
        return $urandom;
    endfunction

    // Result side: random stalls while idling is allowed.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    // Result checker: every transfer is matched with the oldest expected result.
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_seen++;
            if (pending_readings.size() == 0)
                report_error($sformatf("result %0d arrived with no request waiting for it",
                                       results_seen));
            else
            begin
                want = pending_readings.pop_front();
                check_field("flow_established", 32'(got.flow_established),
                            32'(want.flow_established));
                check_field("start_timed_out", 32'(got.start_timed_out),
                            32'(want.start_timed_out));
                check_field("no_flow_timed_out", 32'(got.no_flow_timed_out),
                            32'(want.no_flow_timed_out));
                check_field("sample_valid", 32'(got.sample_valid), 32'(want.sample_valid));
                check_field("pulse_rate_x100", got.pulse_rate_x100, want.pulse_rate_x100);
                check_field("flow_ml_per_min", got.flow_ml_per_min, want.flow_ml_per_min);
                check_field("flow_saturated", 32'(got.flow_saturated),
                            32'(want.flow_saturated));
                check_field("window_pulses", got.window_pulses, want.window_pulses);
                check_field("window_ms", got.window_ms, want.window_ms);
                check_field("water_ml", got.water_ml, want.water_ml);
                check_field("water_valid", 32'(got.water_valid), 32'(want.water_valid));
                check_field("zero fill", 32'(got.pad), 32'(want.pad));
            end
        end
    end

    // Watchdog: a long run of cycles with no transfer on either side means a hang.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results still outstanding",
                     quiet_cycles, pending_readings.size());
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        stim_row_t   row;
        logic [31:0] t_ms;
        logic [31:0] count;
        logic [31:0] now_v;
        logic [31:0] cnt_v;
        int          phase;
        int          n;
        int          pick;
        req_t        req;

        // Right after reset the registers are zero: no calibration and zero timeouts, so
        // the start timeout is flagged at once and every volume reads as uncalibrated.
        add_row(REQ_OBSERVE, 32'd0, 32'd0, 1'b1, golden_of(1'b0, 1'b1, 1'b0, '0, 1'b0));
        add_row(REQ_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                golden_of(1'b0, 1'b1, 1'b0, '0, 1'b0));
        add_row(REQ_OBSERVE, 32'd100, 32'd5, 1'b1, golden_of(1'b1, 1'b0, 1'b1, '0, 1'b0));
        add_row(REQ_WAIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                golden_of(1'b0, 1'b1, 1'b0, '0, 1'b0));
        // One pulse per litre and the longest timeouts. The wait began just before the
        // clock wrapped, so the next requests are only a few ms into it.
        add_setting(32'd100, 16'hFFFF, 16'hFFFF);
        add_row(REQ_WINDOW, 32'd0, 32'd0, 1'b1, golden_of(1'b0, 1'b0, 1'b0, '0, 1'b1));
        add_row(REQ_OBSERVE, 32'd4999, 32'hFFFF_FFFF, 1'b1,
                golden_of(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0));
        // A window one ms short of the minimum is refused and kept; one at the minimum
        // is granted, and the following one sees the pulse count wrap.
        add_row(REQ_SAMPLE, 32'd4999, 32'd10, 1'b1, golden_of(1'b0, 1'b0, 1'b0, 32'd10000, 1'b1));
        add_row(REQ_SAMPLE, 32'd5000, 32'd10, 1'b0, '0);
        add_row(REQ_SAMPLE, 32'd10000, 32'd0, 1'b0, '0);
        // No-flow timeout one ms before and exactly at its threshold.
        add_row(REQ_OBSERVE, 32'd20000, 32'd1, 1'b0, '0);
        add_row(REQ_OBSERVE, 32'd65554999, 32'd1, 1'b0, '0);
        add_row(REQ_OBSERVE, 32'd65555000, 32'd1, 1'b0, '0);
        // Start timeout one ms before and exactly at its threshold.
        add_row(REQ_WAIT, 32'd100, 32'd7, 1'b0, '0);
        add_row(REQ_OBSERVE, 32'd65535099, 32'd7, 1'b0, '0);
        add_row(REQ_OBSERVE, 32'd65535100, 32'd7, 1'b0, '0);
        // Smallest calibration: flow saturates and volumes overflow quickly.
        add_setting(32'd1, 16'd0, 16'd0);
        add_row(REQ_WINDOW, 32'hFFFF_F000, 32'd0, 1'b0, '0);
        add_row(REQ_SAMPLE, 32'h0000_0388, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(REQ_SAMPLE, 32'h0000_1710, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(REQ_OBSERVE, 32'd42949, 32'd42949, 1'b0, '0);
        add_row(REQ_OBSERVE, 32'd1, 32'd42950, 1'b0, '0);
        // Largest calibration: the flow and volume conversions round to small values.
        add_setting(32'hFFFF_FFFF, 16'd1, 16'd1);
        add_row(REQ_WINDOW, 32'd0, 32'd0, 1'b0, '0);
        add_row(REQ_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0);
        add_row(REQ_OBSERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(REQ_WAIT, 32'd5, 32'd3, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_setting)
                apply_settings(row.cal, row.start_to, row.no_flow_to);
            else
            begin
                idle_gap();
                send_request(row.req, row.now_ms, row.count, row.typed, row.golden);
            end
        end

        // Random traffic. Each phase starts from fresh settings and a fresh point on the
        // wrapping clock, then polls like firmware would: time moves forward, the counter
        // creeps up, with observes and samples most common. About one request in ten is
        // noise with arbitrary time and count. One middle phase and the final phase run
        // without any idling on either side.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase != 2) && (phase != RANDOM_PHASES - 1);
            apply_settings(pick_cal(phase), pick_timeout(), pick_timeout());
            t_ms = $urandom;
            count = $urandom;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                begin
                    req = req_t'(2'($urandom_range(0, 3)));
                    now_v = $urandom;
                    cnt_v = $urandom;
                end
                else
                begin
                    t_ms = t_ms + time_step();
                    count = count + count_step();
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        req = REQ_WAIT;
                    else if (pick < 18)
                        req = REQ_WINDOW;
                    else if (pick < 70)
                        req = REQ_OBSERVE;
                    else
                        req = REQ_SAMPLE;
                    now_v = t_ms;
                    cnt_v = count;
                end
                idle_gap();
                send_request(req, now_v, cnt_v, 1'b0, '0);
            end
        end

        // Wait for the last results, then give the block time to show a stray extra one.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
            report_error($sformatf("%0d expected results never arrived", pending_readings.size()));

        $display("Checked %0d results for %0d requests under %0d register settings.",
                 results_seen, items_sent, settings_used);
        $display("Granted samples: %0d, start timeouts: %0d, no-flow timeouts: %0d, %s%0d",
                 samples_granted, start_timeouts, no_flow_timeouts, "saturated volumes: ",
                 volumes_saturated);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/fpm_pkg.sv
hw/rtl/fpm_div.sv
hw/rtl/flow_pulse_monitor.sv
sim/testbench.sv
